// ===== sv/a52_keysetup_inverter_macros.svh =====
// Assertion helpers for the key setup inverter.
`ifndef A52_KEYSETUP_INVERTER_MACROS_SVH
`define A52_KEYSETUP_INVERTER_MACROS_SVH

// Same-cycle implication, quiet while reset is applied.
`define A52_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("a52 keysetup inverter: implication check failed");

// Next-cycle implication, quiet while reset is applied.
`define A52_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("a52 keysetup inverter: sequence check failed");

`endif

// ===== sv/a52ks_pkg.sv =====
package a52ks_pkg;

  localparam int unsigned KeyBits = 64;
  localparam int unsigned R1Len   = 19;
  localparam int unsigned R2Len   = 22;
  localparam int unsigned R3Len   = 23;
  localparam int unsigned R4Len   = 17;
  localparam int unsigned Rows    = R1Len + R2Len + R3Len + R4Len;
  localparam int unsigned FnWidth = 22;

  // Feedback taps.
  localparam int unsigned R1TapA = 13;
  localparam int unsigned R1TapB = 16;
  localparam int unsigned R1TapC = 17;
  localparam int unsigned R1TapD = 18;
  localparam int unsigned R2TapA = 20;
  localparam int unsigned R2TapB = 21;
  localparam int unsigned R3TapA = 7;
  localparam int unsigned R3TapB = 20;
  localparam int unsigned R3TapC = 21;
  localparam int unsigned R3TapD = 22;
  localparam int unsigned R4TapA = 11;
  localparam int unsigned R4TapB = 16;

  // Cells forced to one after key setup.
  localparam int unsigned R1Force = 15;
  localparam int unsigned R2Force = 16;
  localparam int unsigned R3Force = 18;
  localparam int unsigned R4Force = 10;

  typedef struct packed {
    logic [R1Len-1:0]   reg1_bits;
    logic [R2Len-1:0]   reg2_bits;
    logic [R3Len-1:0]   reg3_bits;
    logic [R4Len-1:0]   reg4_bits;
    logic [FnWidth-1:0] frame_number;
  } in_t;

  typedef struct packed {
    logic [KeyBits-1:0] session_key;
    logic               not_solvable;
  } out_t;

  // One register cell: key-bit mask plus constant.
  typedef struct packed {
    logic [KeyBits-1:0] m;
    logic               c;
  } lin_t;

  // One equation of the system.
  typedef struct packed {
    logic               v;
    logic [KeyBits-1:0] m;
    logic               r;
  } row_t;

endpackage

// ===== sv/a52ks_if.sv =====
interface a52ks_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/a52_keysetup_inverter.sv =====
// Flow: capture the beat, clock the registers symbolically, load the equations, eliminate,
// then back-substitute. Elimination passes one equation row by the pivot unit per cycle.
// The block takes no new beat while an item is in work or its result waits.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any result.
`include "a52_keysetup_inverter_macros.svh"

module a52_keysetup_inverter #(
  parameter int unsigned FRAME_BITS = 22
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  a52ks_if.sink   in_i,
  a52ks_if.source out_o
);

  localparam int unsigned KB   = a52ks_pkg::KeyBits;
  localparam int unsigned NR   = a52ks_pkg::Rows;
  localparam int unsigned SymN = KB + FRAME_BITS;
  localparam int unsigned SC_W = $clog2(SymN);
  localparam int unsigned PS_W = $clog2(NR);
  localparam int unsigned CW   = $clog2(KB);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSym  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StElim = 3'd3;
  localparam logic [2:0] StBack = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [SC_W-1:0] sc_q, sc_d;
  logic [PS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]   col_q, col_d;
  logic            seen_q, seen_d;
  logic            found_q, found_d;

  a52ks_pkg::in_t  in_q;
  a52ks_pkg::out_t res_q, res_d;

  // Symbolic register cells.
  a52ks_pkg::lin_t r1_q [a52ks_pkg::R1Len];
  a52ks_pkg::lin_t r2_q [a52ks_pkg::R2Len];
  a52ks_pkg::lin_t r3_q [a52ks_pkg::R3Len];
  a52ks_pkg::lin_t r4_q [a52ks_pkg::R4Len];
  a52ks_pkg::lin_t r1_d [a52ks_pkg::R1Len];
  a52ks_pkg::lin_t r2_d [a52ks_pkg::R2Len];
  a52ks_pkg::lin_t r3_d [a52ks_pkg::R3Len];
  a52ks_pkg::lin_t r4_d [a52ks_pkg::R4Len];

  // Equation ring: slot 0 is the head that meets the pivot unit.
  a52ks_pkg::row_t ring_q [NR];
  a52ks_pkg::row_t ring_d [NR];
  // Pivot stack: slot 0 holds the latest pivot row.
  a52ks_pkg::row_t stk_q [KB];
  a52ks_pkg::row_t stk_d [KB];
  a52ks_pkg::row_t piv_q, piv_d;
  a52ks_pkg::row_t first_q, first_d;
  a52ks_pkg::row_t push;
  a52ks_pkg::row_t head;

  logic [KB-1:0]   key_q, key_d;
  logic [KB-1:0]   kb;
  logic            fb;
  logic [SC_W-1:0] fidx;
  logic            hbit;

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = (state_q == StOut);
  assign out_o.data  = res_q;

  assign head = ring_q[0];
  assign hbit = head.m[col_q];

  // Key bit or frame bit injected at this symbolic clock.
  always_comb begin
    fidx = sc_q - SC_W'(KB);
    kb   = '0;
    fb   = 1'b0;
    if (sc_q < SC_W'(KB)) begin
      kb[sc_q[CW-1:0]] = 1'b1;
    end else if (fidx < SC_W'(a52ks_pkg::FnWidth)) begin
      fb = in_q.frame_number[fidx[4:0]];
    end
  end

  // One symbolic clock of all four registers.
  always_comb begin
    r1_d[0].m = r1_q[a52ks_pkg::R1TapA].m ^ r1_q[a52ks_pkg::R1TapB].m
              ^ r1_q[a52ks_pkg::R1TapC].m ^ r1_q[a52ks_pkg::R1TapD].m ^ kb;
    r1_d[0].c = r1_q[a52ks_pkg::R1TapA].c ^ r1_q[a52ks_pkg::R1TapB].c
              ^ r1_q[a52ks_pkg::R1TapC].c ^ r1_q[a52ks_pkg::R1TapD].c ^ fb;
    for (int j = 1; j < a52ks_pkg::R1Len; j++) r1_d[j] = r1_q[j-1];
    r2_d[0].m = r2_q[a52ks_pkg::R2TapA].m ^ r2_q[a52ks_pkg::R2TapB].m ^ kb;
    r2_d[0].c = r2_q[a52ks_pkg::R2TapA].c ^ r2_q[a52ks_pkg::R2TapB].c ^ fb;
    for (int j = 1; j < a52ks_pkg::R2Len; j++) r2_d[j] = r2_q[j-1];
    r3_d[0].m = r3_q[a52ks_pkg::R3TapA].m ^ r3_q[a52ks_pkg::R3TapB].m
              ^ r3_q[a52ks_pkg::R3TapC].m ^ r3_q[a52ks_pkg::R3TapD].m ^ kb;
    r3_d[0].c = r3_q[a52ks_pkg::R3TapA].c ^ r3_q[a52ks_pkg::R3TapB].c
              ^ r3_q[a52ks_pkg::R3TapC].c ^ r3_q[a52ks_pkg::R3TapD].c ^ fb;
    for (int j = 1; j < a52ks_pkg::R3Len; j++) r3_d[j] = r3_q[j-1];
    r4_d[0].m = r4_q[a52ks_pkg::R4TapA].m ^ r4_q[a52ks_pkg::R4TapB].m ^ kb;
    r4_d[0].c = r4_q[a52ks_pkg::R4TapA].c ^ r4_q[a52ks_pkg::R4TapB].c ^ fb;
    for (int j = 1; j < a52ks_pkg::R4Len; j++) r4_d[j] = r4_q[j-1];
  end

  // Pivot unit: decide what the head row turns into as it rotates to the tail.
  always_comb begin
    push    = head;
    piv_d   = piv_q;
    first_d = first_q;
    seen_d  = seen_q;
    found_d = found_q;
    if (head.v) begin
      if (!seen_q) begin
        // First live row: take it as pivot, or park it for the swap.
        seen_d = 1'b1;
        push.v = 1'b0;
        if (hbit) begin
          piv_d   = head;
          found_d = 1'b1;
        end else begin
          first_d = head;
        end
      end else if (!found_q) begin
        if (hbit) begin
          // Swap: the parked first row takes the pivot's place.
          piv_d   = head;
          found_d = 1'b1;
          push    = first_q;
        end
      end else if (hbit) begin
        push.m = head.m ^ piv_q.m;
        push.r = head.r ^ piv_q.r;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    sc_d    = sc_q;
    pos_d   = pos_q;
    col_d   = col_q;
    res_d   = res_q;
    key_d   = key_q;
    ring_d  = ring_q;
    stk_d   = stk_q;
    unique case (state_q)
      StIdle: begin
        sc_d = '0;
        if (in_i.valid) state_d = StSym;
      end
      StSym: begin
        sc_d = sc_q + SC_W'(1);
        if (sc_q == SC_W'(SymN - 1)) state_d = StLoad;
      end
      StLoad: begin
        // Build equations: forced cells become the constant one.
        for (int j = 0; j < a52ks_pkg::R1Len; j++) begin
          ring_d[j].v = 1'b1;
          ring_d[j].m = (j == a52ks_pkg::R1Force) ? '0 : r1_q[j].m;
          ring_d[j].r = in_q.reg1_bits[j] ^ ((j == a52ks_pkg::R1Force) | r1_q[j].c);
        end
        for (int j = 0; j < a52ks_pkg::R2Len; j++) begin
          ring_d[a52ks_pkg::R1Len+j].v = 1'b1;
          ring_d[a52ks_pkg::R1Len+j].m = (j == a52ks_pkg::R2Force) ? '0 : r2_q[j].m;
          ring_d[a52ks_pkg::R1Len+j].r =
            in_q.reg2_bits[j] ^ ((j == a52ks_pkg::R2Force) | r2_q[j].c);
        end
        for (int j = 0; j < a52ks_pkg::R3Len; j++) begin
          ring_d[a52ks_pkg::R1Len+a52ks_pkg::R2Len+j].v = 1'b1;
          ring_d[a52ks_pkg::R1Len+a52ks_pkg::R2Len+j].m =
            (j == a52ks_pkg::R3Force) ? '0 : r3_q[j].m;
          ring_d[a52ks_pkg::R1Len+a52ks_pkg::R2Len+j].r =
            in_q.reg3_bits[j] ^ ((j == a52ks_pkg::R3Force) | r3_q[j].c);
        end
        for (int j = 0; j < a52ks_pkg::R4Len; j++) begin
          ring_d[NR-a52ks_pkg::R4Len+j].v = 1'b1;
          ring_d[NR-a52ks_pkg::R4Len+j].m = (j == a52ks_pkg::R4Force) ? '0 : r4_q[j].m;
          ring_d[NR-a52ks_pkg::R4Len+j].r =
            in_q.reg4_bits[j] ^ ((j == a52ks_pkg::R4Force) | r4_q[j].c);
        end
        pos_d   = '0;
        col_d   = '0;
        state_d = StElim;
      end
      StElim: begin
        for (int j = 0; j < NR - 1; j++) ring_d[j] = ring_q[j+1];
        ring_d[NR-1] = push;
        pos_d = pos_q + PS_W'(1);
        if (pos_q == PS_W'(NR - 1)) begin
          pos_d = '0;
          if (!found_d) begin
            res_d.session_key  = '0;
            res_d.not_solvable = 1'b1;
            state_d = StOut;
          end else begin
            stk_d[0] = piv_d;
            for (int j = 1; j < KB; j++) stk_d[j] = stk_q[j-1];
            key_d = '0;
            if (col_q == CW'(KB - 1)) begin
              // Hold the top column; back substitution starts there.
              col_d   = col_q;
              state_d = StBack;
            end else begin
              col_d = col_q + CW'(1);
            end
          end
        end
      end
      StBack: begin
        // Pop from the highest column down; col_q counts down from KB - 1.
        key_d[col_q] = stk_q[0].r ^ (^(stk_q[0].m & key_q));
        for (int j = 0; j < KB - 1; j++) stk_d[j] = stk_q[j+1];
        stk_d[KB-1] = stk_q[KB-1];
        col_d = col_q - CW'(1);
        if (col_q == '0) begin
          res_d.session_key  = key_d;
          res_d.not_solvable = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sc_q    <= '0;
      pos_q   <= '0;
      col_q   <= '0;
      seen_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sc_q    <= sc_d;
      pos_q   <= pos_d;
      col_q   <= col_d;
      // Clear the pass flags at each new column.
      if (state_q == StElim && pos_q != PS_W'(NR - 1)) begin
        seen_q  <= seen_d;
        found_q <= found_d;
      end else begin
        seen_q  <= 1'b0;
        found_q <= 1'b0;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
    if (state_q == StIdle) begin
      for (int j = 0; j < a52ks_pkg::R1Len; j++) r1_q[j] <= '0;
      for (int j = 0; j < a52ks_pkg::R2Len; j++) r2_q[j] <= '0;
      for (int j = 0; j < a52ks_pkg::R3Len; j++) r3_q[j] <= '0;
      for (int j = 0; j < a52ks_pkg::R4Len; j++) r4_q[j] <= '0;
    end else if (state_q == StSym) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
    end
    ring_q  <= ring_d;
    stk_q   <= stk_d;
    piv_q   <= piv_d;
    first_q <= first_d;
    key_q   <= key_d;
    res_q   <= res_d;
  end

  `A52_ASSERT_IMP(a_fail_zero, out_o.valid && res_q.not_solvable, res_q.session_key == '0)
  `A52_ASSERT_IMP(a_busy_no_out, in_i.ready, !out_o.valid)
  `A52_ASSERT_NXT(a_sym_to_load, state_q == StSym && sc_q == SC_W'(SymN - 1),
                  state_q == StLoad)

endmodule
